// ===== src/pik_pkg.sv =====
`timescale 1ns / 1ps

package pik_pkg;

  // fixed-point formats
  localparam int COORD_BITS = 24;
  localparam int FRAC_BITS  = 16;
  localparam int LEN_BITS   = COORD_BITS - 1;
  localparam int COS_FRAC   = 30;
  localparam int ANG_BITS   = 20;
  localparam int ST_BITS    = 3;

  // status codes
  localparam logic [ST_BITS-1:0] ST_OK        = 3'd0;
  localparam logic [ST_BITS-1:0] ST_BAD_LEN   = 3'd1;
  localparam logic [ST_BITS-1:0] ST_ORIGIN    = 3'd2;
  localparam logic [ST_BITS-1:0] ST_ZERO_POLE = 3'd3;
  localparam logic [ST_BITS-1:0] ST_COLLINEAR = 3'd4;
  localparam logic [ST_BITS-1:0] ST_UNREACH   = 3'd5;
  localparam logic [ST_BITS-1:0] ST_COS_RANGE = 3'd6;

  // register indexes
  localparam int CFG_IDX_BITS = 3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_UPPER  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LOWER  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_BEND   = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_POLE_EN = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_POLE_X = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_POLE_Y = 3'd5;

  // atan2 unit
  localparam int ATAN_W       = 55;
  localparam int ATAN_NORM    = 39;
  localparam int POS_W        = 6;
  localparam int CORDIC_STEPS = 16;
  localparam int CORDIC_W     = 43;
  localparam int ATAN_LAT     = CORDIC_STEPS + 4;
  localparam int ANG_PI       = 205887;
  localparam int ANG_HALF_PI  = 102944;

  typedef struct packed {
    logic [ATAN_W-1:0] ay;
    logic [ATAN_W-1:0] ax;
    logic              yneg;
    logic              xneg;
  } atan_in_t;

  function automatic logic [ANG_BITS-1:0] atan_tab(input int i);
    logic [ANG_BITS-1:0] v;
    case (i)
      0:  v = 20'd51472;
      1:  v = 20'd30386;
      2:  v = 20'd16055;
      3:  v = 20'd8150;
      4:  v = 20'd4091;
      5:  v = 20'd2047;
      6:  v = 20'd1024;
      7:  v = 20'd512;
      8:  v = 20'd256;
      9:  v = 20'd128;
      10: v = 20'd64;
      11: v = 20'd32;
      12: v = 20'd16;
      13: v = 20'd8;
      14: v = 20'd4;
      15: v = 20'd2;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== src/planar_two_bone_ik_solver_unit.sv =====
`timescale 1ns / 1ps
// throughput: one target transaction per cycle; the whole pipeline advances together
// and holds only while a finished result waits unaccepted at the output register
// the depth comes from the 31-stage fraction divider, the 32-stage square root and
// the 20-stage atan2 units; reset is synchronous, active low, clears all valid bits
// and returns the configuration registers to their defaults

module planar_two_bone_ik_solver_unit (
  input  logic        clk,
  input  logic        rst_n,
  // target transaction
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // [23:0] target_x, [47:24] target_y
  // result transaction
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [2:0] status, [22:3] parent_angle, [42:23] child_angle
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  localparam int CW      = pik_pkg::COORD_BITS;
  localparam int LW      = pik_pkg::LEN_BITS;
  localparam int CF      = pik_pkg::COS_FRAC;
  localparam int AB      = pik_pkg::ANG_BITS;
  localparam int SB      = pik_pkg::ST_BITS;
  localparam int D2_W    = 2 * CW;          // squared coordinates
  localparam int NUM_W   = D2_W + 1;        // signed numerator / cross product
  localparam int SUM_W   = LW + 2;
  localparam int SUM2_W  = 2 * SUM_W;
  localparam int CM_W    = CF + 1;          // cosine magnitude, Q.30
  localparam int RT_W    = 2 * CF + 2;      // square root working width
  localparam int PROD_W  = LW + CM_W;
  localparam int KW      = pik_pkg::ATAN_W;
  localparam int DIV_N   = CF;
  localparam int SQ_N    = CF + 1;
  localparam int AL      = pik_pkg::ATAN_LAT;

  localparam logic [LW-1:0]          LEN_ONE  = LW'(1 << pik_pkg::FRAC_BITS);
  localparam logic signed [NUM_W-1:0] CR_LIM  = NUM_W'(1 << pik_pkg::FRAC_BITS);
  localparam logic [CM_W-1:0]        COS_ONE  = CM_W'(1 << CF);
  localparam logic [CM_W-1:0]        COS_LIM  =
    CM_W'((1 << CF) + (7 << (CF - pik_pkg::FRAC_BITS)));
  localparam logic [RT_W-1:0]        SQ_ONE   = RT_W'(1) << (2 * CF);
  localparam logic [LW-1:0]          SLACK    = LW'(7);
  localparam logic signed [AB-1:0]   PI_A     = AB'(pik_pkg::ANG_PI);

  typedef struct packed {
    logic          vld;
    logic [SB-1:0] st;
    logic          sneg;
    logic          cneg;
    logic          qerr;
    logic          xneg;
    logic          yneg;
    logic [CW-1:0] xm;
    logic [CW-1:0] ym;
  } meta_t;

  // pipeline advance: move when the output register is free or being drained
  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;
  assign cfg_ready = 1'b1;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [LW-1:0]        upper_length_r, lower_length_r;
  logic                 bend_choice_r, pole_enable_r;
  logic signed [CW-1:0] pole_x_r, pole_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upper_length_r <= LEN_ONE;
      lower_length_r <= LEN_ONE;
      bend_choice_r  <= 1'b0;
      pole_enable_r  <= 1'b0;
      pole_x_r       <= '0;
      pole_y_r       <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pik_pkg::CFG_UPPER:   upper_length_r <= cfg_data[LW-1:0];
        pik_pkg::CFG_LOWER:   lower_length_r <= cfg_data[LW-1:0];
        pik_pkg::CFG_BEND:    bend_choice_r  <= cfg_data[0];
        pik_pkg::CFG_POLE_EN: pole_enable_r  <= cfg_data[0];
        pik_pkg::CFG_POLE_X:  pole_x_r       <= $signed(cfg_data[CW-1:0]);
        pik_pkg::CFG_POLE_Y:  pole_y_r       <= $signed(cfg_data[CW-1:0]);
        default: ;
      endcase
    end
  end

  // values that depend only on configuration, refreshed every cycle; the user must
  // make config changes only while the pipeline is empty; the block does not enforce it
  logic [2*LW-1:0]   l11_r, l22_r, l12_r, dm2_r;
  logic [SUM2_W-1:0] sum2_r;
  logic              dgt7_r;
  logic [D2_W-1:0]   pxx_r, pyy_r;
  logic [D2_W-1:0]   lsq_r, den_r;
  logic              pole_small_r;
  logic [SUM_W-1:0]  sum_w;
  logic [LW-1:0]     diff_w, dm_w;
  logic signed [D2_W-1:0] pxx_w, pyy_w;
  logic [D2_W:0]     p2_w;

  assign sum_w  = SUM_W'(upper_length_r) + SUM_W'(lower_length_r) + SUM_W'(SLACK);
  assign diff_w = (upper_length_r > lower_length_r) ? upper_length_r - lower_length_r
                                                    : lower_length_r - upper_length_r;
  assign dm_w   = diff_w - SLACK;
  assign pxx_w  = D2_W'(pole_x_r) * D2_W'(pole_x_r);
  assign pyy_w  = D2_W'(pole_y_r) * D2_W'(pole_y_r);
  assign p2_w   = (D2_W+1)'(pxx_r) + (D2_W+1)'(pyy_r);

  always_ff @(posedge clk) begin
    l11_r        <= (2*LW)'(upper_length_r) * (2*LW)'(upper_length_r);
    l22_r        <= (2*LW)'(lower_length_r) * (2*LW)'(lower_length_r);
    l12_r        <= (2*LW)'(upper_length_r) * (2*LW)'(lower_length_r);
    sum2_r       <= SUM2_W'(sum_w) * SUM2_W'(sum_w);
    dgt7_r       <= diff_w > SLACK;
    dm2_r        <= (2*LW)'(dm_w) * (2*LW)'(dm_w);
    pxx_r        <= pxx_w;
    pyy_r        <= pyy_w;
    lsq_r        <= D2_W'(l11_r) + D2_W'(l22_r);
    den_r        <= D2_W'({l12_r, 1'b0});
    pole_small_r <= p2_w <= (D2_W+1)'(1);
  end

  // ---------------------------------------------------------------------------
  // s1: take the target, split into magnitude and sign
  // ---------------------------------------------------------------------------
  meta_t m1_r, m1_nxt;
  logic signed [CW-1:0] x1_r, y1_r;
  logic [CW-1:0] xin, yin;

  assign xin = in_tdata[CW-1:0];
  assign yin = in_tdata[2*CW-1:CW];

  always_comb begin
    m1_nxt      = '0;
    m1_nxt.vld  = in_tvalid;
    m1_nxt.st   = pik_pkg::ST_OK;
    m1_nxt.xneg = xin[CW-1];
    m1_nxt.yneg = yin[CW-1];
    m1_nxt.xm   = xin[CW-1] ? CW'(~xin + 1'b1) : xin;
    m1_nxt.ym   = yin[CW-1] ? CW'(~yin + 1'b1) : yin;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) m1_r <= '0;
    else if (en) m1_r <= m1_nxt;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1_r <= $signed(xin);
      y1_r <= $signed(yin);
    end
  end

  // ---------------------------------------------------------------------------
  // s2: squares and pole cross terms
  // ---------------------------------------------------------------------------
  meta_t m2_r;
  logic [D2_W-1:0]        xx2_r, yy2_r;
  logic signed [D2_W-1:0] xpy2_r, ypx2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) m2_r <= '0;
    else if (en) m2_r <= m1_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xx2_r  <= D2_W'(m1_r.xm) * D2_W'(m1_r.xm);
      yy2_r  <= D2_W'(m1_r.ym) * D2_W'(m1_r.ym);
      xpy2_r <= D2_W'(x1_r) * D2_W'(pole_y_r);
      ypx2_r <= D2_W'(y1_r) * D2_W'(pole_x_r);
    end
  end

  // ---------------------------------------------------------------------------
  // s3: squared distance and cross product
  // ---------------------------------------------------------------------------
  meta_t m3_r;
  logic [D2_W-1:0]         d23_r;
  logic signed [NUM_W-1:0] cr3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) m3_r <= '0;
    else if (en) m3_r <= m2_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d23_r <= xx2_r + yy2_r;
      cr3_r <= NUM_W'(xpy2_r) - NUM_W'(ypx2_r);
    end
  end

  // ---------------------------------------------------------------------------
  // s4: error checks in priority order, bend side, cosine numerator
  // ---------------------------------------------------------------------------
  meta_t m4_r, m4_nxt;
  logic signed [NUM_W-1:0] num4_r;

  always_comb begin
    m4_nxt = m3_r;
    if (upper_length_r == '0 || lower_length_r == '0) begin
      m4_nxt.st = pik_pkg::ST_BAD_LEN;
    end else if (d23_r == '0) begin
      m4_nxt.st = pik_pkg::ST_ORIGIN;
    end else if (pole_enable_r && pole_small_r) begin
      m4_nxt.st = pik_pkg::ST_ZERO_POLE;
    end else if (pole_enable_r && cr3_r <= CR_LIM && cr3_r >= -CR_LIM) begin
      m4_nxt.st = pik_pkg::ST_COLLINEAR;
    end else if (SUM2_W'(d23_r) > sum2_r) begin
      m4_nxt.st = pik_pkg::ST_UNREACH;
    end else if (dgt7_r && d23_r < D2_W'(dm2_r)) begin
      m4_nxt.st = pik_pkg::ST_UNREACH;
    end else begin
      m4_nxt.st = pik_pkg::ST_OK;
    end
    // positive cross product with the pole means negative sine
    if (pole_enable_r) m4_nxt.sneg = !cr3_r[NUM_W-1] && (cr3_r != '0);
    else m4_nxt.sneg = !bend_choice_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) m4_r <= '0;
    else if (en) m4_r <= m4_nxt;
  end

  always_ff @(posedge clk) begin
    if (en) num4_r <= $signed(NUM_W'(d23_r) - NUM_W'(lsq_r));
  end

  // ---------------------------------------------------------------------------
  // s5: numerator magnitude
  // ---------------------------------------------------------------------------
  meta_t m5_r, m5_nxt;
  logic [D2_W-1:0]  an5_r;
  logic [NUM_W-1:0] numu, numabs;

  assign numu   = num4_r;
  assign numabs = numu[NUM_W-1] ? NUM_W'(~numu + 1'b1) : numu;

  always_comb begin
    m5_nxt      = m4_r;
    m5_nxt.cneg = num4_r[NUM_W-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) m5_r <= '0;
    else if (en) m5_r <= m5_nxt;
  end

  always_ff @(posedge clk) begin
    if (en) an5_r <= numabs[D2_W-1:0];
  end

  // ---------------------------------------------------------------------------
  // s6 plus divider: integer bit of the cosine, then one fraction bit per stage
  // ---------------------------------------------------------------------------
  meta_t           dm_r [0:DIV_N];
  logic [D2_W-1:0] dv_r [0:DIV_N];
  logic [CM_W-1:0] dc_r [0:DIV_N];
  meta_t           m6_nxt;
  logic            q6;

  assign q6 = an5_r >= den_r;

  always_comb begin
    m6_nxt      = m5_r;
    m6_nxt.qerr = {1'b0, an5_r} >= {den_r, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) dm_r[0] <= '0;
    else if (en) dm_r[0] <= m6_nxt;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_r[0] <= q6 ? an5_r - den_r : an5_r;
      dc_r[0] <= {q6, {CF{1'b0}}};
    end
  end

  for (genvar k = 0; k < DIV_N; k++) begin : g_div
    logic [D2_W:0] sh;
    logic          ge;
    assign sh = {dv_r[k], 1'b0};
    assign ge = sh >= {1'b0, den_r};

    always_ff @(posedge clk) begin
      if (!rst_n) dm_r[k+1] <= '0;
      else if (en) dm_r[k+1] <= dm_r[k];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_r[k+1] <= ge ? D2_W'(sh - {1'b0, den_r}) : D2_W'(sh);
        dc_r[k+1] <= dc_r[k] | (CM_W'(ge) << (CF - 1 - k));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // cosine range check and clamp to one
  // ---------------------------------------------------------------------------
  meta_t           mc_r, mc_nxt;
  logic [CM_W-1:0] cmc_r;

  always_comb begin
    mc_nxt = dm_r[DIV_N];
    if (mc_nxt.st == pik_pkg::ST_OK && (mc_nxt.qerr || dc_r[DIV_N] > COS_LIM)) begin
      mc_nxt.st = pik_pkg::ST_COS_RANGE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) mc_r <= '0;
    else if (en) mc_r <= mc_nxt;
  end

  always_ff @(posedge clk) begin
    if (en) cmc_r <= (dc_r[DIV_N] > COS_ONE) ? COS_ONE : dc_r[DIV_N];
  end

  // ---------------------------------------------------------------------------
  // sine: 1 - c^2, then a restoring square root, one result bit per stage
  // ---------------------------------------------------------------------------
  meta_t           mq_r;
  logic [RT_W-1:0] cc_r;
  logic [CM_W-1:0] cmq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) mq_r <= '0;
    else if (en) mq_r <= mc_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cc_r  <= RT_W'(cmc_r) * RT_W'(cmc_r);
      cmq_r <= cmc_r;
    end
  end

  meta_t           sm_r [0:SQ_N];
  logic [RT_W-1:0] sv_r [0:SQ_N];
  logic [RT_W-1:0] sr_r [0:SQ_N];
  logic [CM_W-1:0] sc_r [0:SQ_N];

  always_ff @(posedge clk) begin
    if (!rst_n) sm_r[0] <= '0;
    else if (en) sm_r[0] <= mq_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sv_r[0] <= SQ_ONE - cc_r;
      sr_r[0] <= '0;
      sc_r[0] <= cmq_r;
    end
  end

  for (genvar k = 0; k < SQ_N; k++) begin : g_sqrt
    logic [RT_W-1:0] bitv, t;
    logic            ge;
    assign bitv = RT_W'(1) << (2 * CF - 2 * k);
    assign t    = sr_r[k] + bitv;
    assign ge   = sv_r[k] >= t;

    always_ff @(posedge clk) begin
      if (!rst_n) sm_r[k+1] <= '0;
      else if (en) sm_r[k+1] <= sm_r[k];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sv_r[k+1] <= ge ? sv_r[k] - t : sv_r[k];
        sr_r[k+1] <= ge ? (sr_r[k] >> 1) + bitv : (sr_r[k] >> 1);
        sc_r[k+1] <= sc_r[k];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // knee terms: L2*s and L2*|c|
  // ---------------------------------------------------------------------------
  meta_t             mm_r;
  logic [CM_W-1:0]   s_m_r, cm_m_r;
  logic [PROD_W-1:0] l2s_m_r, l2c_m_r;

  always_ff @(posedge clk) begin
    if (!rst_n) mm_r <= '0;
    else if (en) mm_r <= sm_r[SQ_N];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_m_r   <= sr_r[SQ_N][CM_W-1:0];
      cm_m_r  <= sc_r[SQ_N];
      l2s_m_r <= PROD_W'(lower_length_r) * PROD_W'(sr_r[SQ_N][CM_W-1:0]);
      l2c_m_r <= PROD_W'(lower_length_r) * PROD_W'(sc_r[SQ_N]);
    end
  end

  // ---------------------------------------------------------------------------
  // k1 = L1 + L2*c as magnitude and sign
  // ---------------------------------------------------------------------------
  meta_t             mk_r;
  logic [CM_W-1:0]   s_k_r, cm_k_r;
  logic [PROD_W-1:0] l2s_k_r;
  logic [KW-1:0]     k1m_r, k1m_nxt, l1s, l2c;
  logic              k1neg_r, k1neg_nxt;

  assign l1s = KW'({upper_length_r, {CF{1'b0}}});
  assign l2c = KW'(l2c_m_r);

  always_comb begin
    k1neg_nxt = 1'b0;
    if (!mm_r.cneg) begin
      k1m_nxt = l1s + l2c;
    end else if (l2c > l1s) begin
      k1m_nxt   = l2c - l1s;
      k1neg_nxt = 1'b1;
    end else begin
      k1m_nxt = l1s - l2c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) mk_r <= '0;
    else if (en) mk_r <= mm_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_k_r   <= s_m_r;
      cm_k_r  <= cm_m_r;
      l2s_k_r <= l2s_m_r;
      k1m_r   <= k1m_nxt;
      k1neg_r <= k1neg_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // three atan2 pipelines in lockstep, with valid and status riding alongside
  // ---------------------------------------------------------------------------
  pik_pkg::atan_in_t       at_chi, at_tgt, at_knee;
  logic signed [AB-1:0]    ang_chi, ang_tgt, ang_knee;

  always_comb begin
    at_chi.ay   = KW'(s_k_r);
    at_chi.ax   = KW'(cm_k_r);
    at_chi.yneg = mk_r.sneg;
    at_chi.xneg = mk_r.cneg;
    at_tgt.ay   = KW'(mk_r.ym);
    at_tgt.ax   = KW'(mk_r.xm);
    at_tgt.yneg = mk_r.yneg;
    at_tgt.xneg = mk_r.xneg;
    at_knee.ay   = KW'(l2s_k_r);
    at_knee.ax   = k1m_r;
    at_knee.yneg = mk_r.sneg;
    at_knee.xneg = k1neg_r;
  end

  pik_atan2 u_atan_child (.clk(clk), .en(en), .a_in(at_chi),  .ang(ang_chi));
  pik_atan2 u_atan_tgt   (.clk(clk), .en(en), .a_in(at_tgt),  .ang(ang_tgt));
  pik_atan2 u_atan_knee  (.clk(clk), .en(en), .a_in(at_knee), .ang(ang_knee));

  logic          av_r  [0:AL-1];
  logic [SB-1:0] ast_r [0:AL-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      av_r[0]  <= 1'b0;
      ast_r[0] <= pik_pkg::ST_OK;
    end else if (en) begin
      av_r[0]  <= mk_r.vld;
      ast_r[0] <= mk_r.st;
    end
  end

  for (genvar k = 1; k < AL; k++) begin : g_adly
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        av_r[k]  <= 1'b0;
        ast_r[k] <= pik_pkg::ST_OK;
      end else if (en) begin
        av_r[k]  <= av_r[k-1];
        ast_r[k] <= ast_r[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  logic                 out_valid_r;
  logic [SB-1:0]        out_st_r;
  logic signed [AB-1:0] out_par_r, out_chi_r;
  logic                 st_ok;

  assign st_ok = ast_r[AL-1] == pik_pkg::ST_OK;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (en) out_valid_r <= av_r[AL-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_st_r  <= ast_r[AL-1];
      out_par_r <= st_ok ? ang_tgt - ang_knee : '0;
      out_chi_r <= st_ok ? ang_chi : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_chi_r, out_par_r, out_st_r};

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_st_r != pik_pkg::ST_OK) |-> (out_par_r == '0) && (out_chi_r == '0))
    else $error("angles not zero on error status");

  a_cos_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    mc_r.vld && (mc_r.st == pik_pkg::ST_OK) |-> cmc_r <= COS_ONE)
    else $error("cosine above one after clamp");

  a_sine_range: assert property (@(posedge clk) disable iff (!rst_n)
    mm_r.vld && (mm_r.st == pik_pkg::ST_OK) |-> s_m_r <= COS_ONE)
    else $error("sine above one");

  a_child_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_st_r == pik_pkg::ST_OK) |-> (out_chi_r <= PI_A) && (out_chi_r >= -PI_A))
    else $error("child angle outside pi");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_valid_r && !out_tready)
    else $error("input stalled without a held result");

endmodule

// ===== src/pik_atan2.sv =====
`timescale 1ns / 1ps

module pik_atan2 (
  input  logic                                 clk,
  input  logic                                 en,
  input  pik_pkg::atan_in_t                    a_in,
  output logic signed [pik_pkg::ANG_BITS-1:0]  ang
);

  localparam int W  = pik_pkg::ATAN_W;
  localparam int NB = pik_pkg::ATAN_NORM;
  localparam int PW = pik_pkg::POS_W;
  localparam int CWD = pik_pkg::CORDIC_W;
  localparam int AB = pik_pkg::ANG_BITS;
  localparam int NS = pik_pkg::CORDIC_STEPS;
  localparam int NF = pik_pkg::ATAN_LAT - 1;

  localparam logic signed [AB-1:0] PI_A   = AB'(pik_pkg::ANG_PI);
  localparam logic signed [AB-1:0] HALF_A = AB'(pik_pkg::ANG_HALF_PI);

  typedef struct packed {
    logic yneg;
    logic xneg;
    logic zero;
  } flag_t;

  function automatic logic [PW-1:0] msb_pos(input logic [W-1:0] v);
    logic [PW-1:0] p;
    p = '0;
    for (int i = 0; i < W; i++) begin
      if (v[i]) p = PW'(i);
    end
    return p;
  endfunction

  flag_t flg_r [0:NF-1];

  logic [W-1:0]  ax1_r, ay1_r, mx1_r;
  logic [W-1:0]  ax2_r, ay2_r;
  logic [PW-1:0] pos2_r;

  logic signed [CWD-1:0] cx_r [0:NS];
  logic signed [CWD-1:0] cy_r [0:NS];
  logic signed [AB-1:0]  ca_r [0:NS];
  logic signed [AB-1:0]  ang_r, ang_nxt;

  logic [W+NB-1:0] wx, wy;

  // magnitude compare
  always_ff @(posedge clk) begin
    if (en) begin
      ax1_r    <= a_in.ax;
      ay1_r    <= a_in.ay;
      mx1_r    <= (a_in.ax > a_in.ay) ? a_in.ax : a_in.ay;
      flg_r[0] <= {a_in.yneg, a_in.xneg, (a_in.ax == '0) && (a_in.ay == '0)};
    end
  end

  // leading one of the larger magnitude
  always_ff @(posedge clk) begin
    if (en) begin
      ax2_r    <= ax1_r;
      ay2_r    <= ay1_r;
      pos2_r   <= msb_pos(mx1_r);
      flg_r[1] <= flg_r[0];
    end
  end

  // scale so the larger magnitude has its leading one at bit NB
  assign wx = {ax2_r, {NB{1'b0}}} >> pos2_r;
  assign wy = {ay2_r, {NB{1'b0}}} >> pos2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      cx_r[0]  <= $signed(CWD'(wx[NB+1:0]));
      cy_r[0]  <= $signed(CWD'(wy[NB+1:0]));
      ca_r[0]  <= '0;
      flg_r[2] <= flg_r[1];
    end
  end

  // vectoring iterations, one per stage
  for (genvar i = 0; i < NS; i++) begin : g_cordic
    logic signed [CWD-1:0] dx, dy;
    logic signed [AB-1:0]  step;
    assign dx   = cy_r[i] >>> i;
    assign dy   = cx_r[i] >>> i;
    assign step = $signed(pik_pkg::atan_tab(i));

    always_ff @(posedge clk) begin
      if (en) begin
        if (!cy_r[i][CWD-1]) begin
          cx_r[i+1] <= cx_r[i] + dx;
          cy_r[i+1] <= cy_r[i] - dy;
          ca_r[i+1] <= ca_r[i] + step;
        end else begin
          cx_r[i+1] <= cx_r[i] - dx;
          cy_r[i+1] <= cy_r[i] + dy;
          ca_r[i+1] <= ca_r[i] - step;
        end
        flg_r[i+3] <= flg_r[i+2];
      end
    end
  end

  // clamp to the first quadrant, then fold in the signs
  always_comb begin
    ang_nxt = ca_r[NS];
    if (flg_r[NF-1].zero) ang_nxt = '0;
    if (ang_nxt[AB-1]) ang_nxt = '0;
    if (ang_nxt > HALF_A) ang_nxt = HALF_A;
    if (flg_r[NF-1].xneg) ang_nxt = PI_A - ang_nxt;
    if (flg_r[NF-1].yneg) ang_nxt = -ang_nxt;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ang_r <= ang_nxt;
    end
  end

  assign ang = ang_r;

endmodule

// ===== tb/planar_two_bone_ik_solver_unit_tb.sv =====
`timescale 1ns / 1ps

module planar_two_bone_ik_solver_unit_tb;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;   // [23:0] target_x, [47:24] target_y
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;  // [2:0] status, [22:3] parent_angle, [42:23] child_angle
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [23:0] cfg_data;

  localparam int PIPE_LAT = 92;

  typedef struct packed {
    logic [pik_pkg::ST_BITS-1:0]  status;
    logic [pik_pkg::ANG_BITS-1:0] parent;
    logic [pik_pkg::ANG_BITS-1:0] child;
  } joint_sol_t;

  // solver configuration mirror
  logic [pik_pkg::LEN_BITS-1:0]   len_upper, len_lower;
  logic                           bend_neg, pole_on;
  logic [pik_pkg::COORD_BITS-1:0] pole_xr, pole_yr;

  int mismatches = 0;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    mismatches++;
  endtask

  function automatic longint sx(input logic [63:0] v, input int bits);
    logic [63:0] sb;
    sb = 64'd1 << (bits - 1);
    v = v & ((sb << 1) - 1);
    return longint'(v ^ sb) - longint'(sb);
  endfunction

  function automatic longint sra(input longint v, input int s);
    if (v >= 0) return v >>> s;
    return -((-(v + 1)) >>> s) - 1;
  endfunction

  function automatic longint unsigned umag(input longint v);
    return v < 0 ? 64'd0 - 64'(v) : 64'(v);
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint cordic_angle(input longint unsigned ay, input bit yneg,
                                          input longint unsigned ax, input bit xneg);
    longint a, x, y, dx, dy;
    longint unsigned mx;
    a = 0;
    if (ax != 0 || ay != 0) begin
      mx = ax > ay ? ax : ay;
      while (mx >= (64'd1 << 40)) begin ax >>= 1; ay >>= 1; mx >>= 1; end
      while (mx < (64'd1 << 39)) begin ax <<= 1; ay <<= 1; mx <<= 1; end
      x = longint'(ax);
      y = longint'(ay);
      for (int i = 0; i < pik_pkg::CORDIC_STEPS; i++) begin
        dx = sra(y, i);
        dy = sra(x, i);
        if (y >= 0) begin
          x += dx; y -= dy; a += longint'(pik_pkg::atan_tab(i));
        end else begin
          x -= dx; y += dy; a -= longint'(pik_pkg::atan_tab(i));
        end
      end
      if (a < 0) a = 0;
      if (a > pik_pkg::ANG_HALF_PI) a = pik_pkg::ANG_HALF_PI;
    end
    if (xneg) a = pik_pkg::ANG_PI - a;
    if (yneg) a = -a;
    return a;
  endfunction

  // law of cosines solve, error checks in priority order
  function automatic logic [pik_pkg::ST_BITS-1:0] solve_joints(input longint x,
                                                               input longint y,
                                                               output longint th1,
                                                               output longint th2);
    longint unsigned l1, l2, d2, sum, diff, den, an, q, r, cm, s, pm;
    longint num, c, k1, px, py, cr;
    bit sneg, cneg;
    th1 = 0;
    th2 = 0;
    l1 = len_upper;
    l2 = len_lower;
    if (l1 == 0 || l2 == 0) return pik_pkg::ST_BAD_LEN;
    d2 = umag(x) * umag(x) + umag(y) * umag(y);
    if (d2 == 0) return pik_pkg::ST_ORIGIN;
    sneg = !bend_neg;
    if (pole_on) begin
      px = sx(pole_xr, pik_pkg::COORD_BITS);
      py = sx(pole_yr, pik_pkg::COORD_BITS);
      pm = umag(px) * umag(px) + umag(py) * umag(py);
      if (pm <= 1) return pik_pkg::ST_ZERO_POLE;
      cr = x * py - y * px;
      if (umag(cr) <= (64'd1 << pik_pkg::FRAC_BITS)) return pik_pkg::ST_COLLINEAR;
      sneg = cr > 0;
    end
    sum = l1 + l2 + 7;
    if ((sum >> 32) == 0 && d2 > sum * sum) return pik_pkg::ST_UNREACH;
    diff = l1 > l2 ? l1 - l2 : l2 - l1;
    if (diff > 7 && d2 < (diff - 7) * (diff - 7)) return pik_pkg::ST_UNREACH;
    num = longint'(d2) - longint'(l1 * l1 + l2 * l2);
    den = 2 * l1 * l2;
    an = umag(num);
    q = an / den;
    if (q >= 2) return pik_pkg::ST_COS_RANGE;
    r = an % den;
    cm = q << pik_pkg::COS_FRAC;
    for (int i = pik_pkg::COS_FRAC - 1; i >= 0; i--) begin
      r <<= 1;
      if (r >= den) begin
        r -= den;
        cm |= 64'd1 << i;
      end
    end
    if (cm > (64'd1 << pik_pkg::COS_FRAC)
             + (64'd7 << (pik_pkg::COS_FRAC - pik_pkg::FRAC_BITS)))
      return pik_pkg::ST_COS_RANGE;
    if (cm > (64'd1 << pik_pkg::COS_FRAC)) cm = 64'd1 << pik_pkg::COS_FRAC;
    cneg = num < 0;
    c = cneg ? -longint'(cm) : longint'(cm);
    s = int_sqrt((64'd1 << (2 * pik_pkg::COS_FRAC)) - cm * cm);
    th2 = cordic_angle(s, sneg, cm, cneg);
    k1 = longint'(l1 << pik_pkg::COS_FRAC) + longint'(l2) * c;
    th1 = cordic_angle(umag(y), y < 0, umag(x), x < 0)
        - cordic_angle(l2 * s, sneg, umag(k1), k1 < 0);
    return pik_pkg::ST_OK;
  endfunction

  function automatic joint_sol_t predict_joints(input logic [47:0] tgt);
    joint_sol_t e;
    longint t1, t2;
    e.status = solve_joints(sx(tgt[23:0], pik_pkg::COORD_BITS),
                            sx(tgt[47:24], pik_pkg::COORD_BITS), t1, t2);
    if (e.status != pik_pkg::ST_OK) begin
      t1 = 0;
      t2 = 0;
    end
    e.parent = t1[pik_pkg::ANG_BITS-1:0];
    e.child  = t2[pik_pkg::ANG_BITS-1:0];
    return e;
  endfunction

  // expected joint solutions in target order
  class joint_scoreboard;
    joint_sol_t pending[$];

    function void note_target(input logic [47:0] tgt);
      pending.push_back(predict_joints(tgt));
    endfunction

    task check_solution(input logic [47:0] d);
      joint_sol_t e;
      if (pending.size() == 0) begin
        report_mismatch("unexpected result", d, 0);
        return;
      end
      e = pending.pop_front();
      if (d[2:0] != e.status) report_mismatch("status", d[2:0], e.status);
      if (d[22:3] != e.parent) report_mismatch("parent_angle", d[22:3], e.parent);
      if (d[42:23] != e.child) report_mismatch("child_angle", d[42:23], e.child);
      if (d[47:43] != 0) report_mismatch("pad bits", d[47:43], 0);
    endtask
  endclass

  joint_scoreboard sb = new();

  planar_two_bone_ik_solver_unit dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // idling percentages and the receiver hold-off
  int in_idle_pct = 0;
  int out_idle_pct = 0;
  bit hold_off = 0;

  // monitor: inputs accepted at the edge go to the scoreboard, accepted results are checked against it
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_target(in_tdata);
    if (rst_n && out_tvalid && out_tready) sb.check_solution(out_tdata);
  end

  // receiver stalls
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= !hold_off && ($urandom_range(99) >= out_idle_pct);
  end

  task automatic send_target(input logic [23:0] x, input logic [23:0] y);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {y, x};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [23:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      pik_pkg::CFG_UPPER:   len_upper = v[pik_pkg::LEN_BITS-1:0];
      pik_pkg::CFG_LOWER:   len_lower = v[pik_pkg::LEN_BITS-1:0];
      pik_pkg::CFG_BEND:    bend_neg  = v[0];
      pik_pkg::CFG_POLE_EN: pole_on   = v[0];
      pik_pkg::CFG_POLE_X:  pole_xr   = v;
      pik_pkg::CFG_POLE_Y:  pole_yr   = v;
      default: ;
    endcase
  endtask

  task automatic set_solver(input logic [23:0] l1, input logic [23:0] l2, input bit bn,
                            input bit pe, input logic [23:0] px, input logic [23:0] py);
    write_reg(pik_pkg::CFG_UPPER, l1);
    write_reg(pik_pkg::CFG_LOWER, l2);
    write_reg(pik_pkg::CFG_BEND, {23'd0, bn});
    write_reg(pik_pkg::CFG_POLE_EN, {23'd0, pe});
    write_reg(pik_pkg::CFG_POLE_X, px);
    write_reg(pik_pkg::CFG_POLE_Y, py);
  endtask

  // mostly targets within the reach square, some near the origin, sometimes anywhere
  task automatic random_target(input int reach);
    logic [23:0] x, y;
    int k;
    k = $urandom_range(9);
    if (k < 6) begin
      x = 24'(int'($urandom_range(2 * reach)) - reach);
      y = 24'(int'($urandom_range(2 * reach)) - reach);
    end else if (k < 8) begin
      x = 24'(int'($urandom_range(1024)) - 512);
      y = 24'(int'($urandom_range(1024)) - 512);
    end else begin
      x = 24'($urandom());
      y = 24'($urandom());
    end
    send_target(x, y);
  endtask

  task automatic random_phase(input int n);
    int reach;
    reach = len_upper + len_lower + 16;
    if (reach > 8388607) reach = 8388607;
    for (int i = 0; i < n; i++) random_target(reach);
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    len_upper = 23'(1 << pik_pkg::FRAC_BITS);
    len_lower = 23'(1 << pik_pkg::FRAC_BITS);
    bend_neg = 0;
    pole_on = 0;
    pole_xr = '0;
    pole_yr = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset defaults, origin, extremes, edge of reach
    in_idle_pct = 25;
    out_idle_pct = 71;
    send_target(24'd0, 24'd0);
    send_target(24'h020000, 24'd0);
    send_target(24'h020007, 24'd0);
    send_target(24'h020008, 24'd0);
    send_target(24'd0, 24'h010000);
    send_target(24'h800000, 24'h800000);
    send_target(24'h7fffff, 24'h7fffff);
    send_target(24'hffffff, 24'd1);
    send_target(24'h000001, 24'h000000);
    send_target(24'hff0000, 24'h00b505);
    drain();

    // bad lengths
    write_reg(pik_pkg::CFG_UPPER, 24'd0);
    send_target(24'h010000, 24'h010000);
    drain();
    set_solver(24'h010000, 24'd0, 1'b1, 1'b0, 24'd0, 24'd0);
    send_target(24'h010000, 24'h010000);
    drain();

    // unequal lengths: inner ring, negative bend
    set_solver(24'h030000, 24'h010000, 1'b1, 1'b0, 24'd0, 24'd0);
    send_target(24'h010000, 24'd0);
    send_target(24'h020000, 24'd0);
    send_target(24'h01fff9, 24'd0);
    send_target(24'h040000, 24'd0);
    drain();

    // pole: zero, unit, collinear, both sides
    set_solver(24'h010000, 24'h010000, 1'b0, 1'b1, 24'd0, 24'd0);
    send_target(24'h010000, 24'h008000);
    drain();
    write_reg(pik_pkg::CFG_POLE_X, 24'd1);
    send_target(24'h010000, 24'h008000);
    drain();
    write_reg(pik_pkg::CFG_POLE_Y, 24'h010000);
    write_reg(pik_pkg::CFG_POLE_X, 24'd0);
    send_target(24'h000001, 24'h010000);
    send_target(24'h010000, 24'h008000);
    send_target(24'hff0000, 24'h008000);
    drain();

    // random phases over several settings, largest lengths included
    set_solver(24'h010000, 24'h010000, 1'b0, 1'b0, 24'd0, 24'd0);
    random_phase(120);
    set_solver(24'h7fffff, 24'h7fffff, 1'b1, 1'b0, 24'h800000, 24'h7fffff);
    random_phase(80);

    // pressure: long receiver hold-off while targets keep coming
    in_idle_pct = 71;
    out_idle_pct = 25;
    set_solver(24'h018000, 24'h00c000, 1'b0, 1'b1, 24'hff8000, 24'h012345);
    fork
      begin
        hold_off = 1;
        repeat (400) @(posedge clk);
        hold_off = 0;
      end
      random_phase(150);
    join
    set_solver(24'h000001, 24'h000001, 1'b1, 1'b1, 24'h7fffff, 24'h800000);
    random_phase(60);
    set_solver(24'h123456, 24'h0a5a5a, 1'b1, 1'b1, 24'h000001, 24'hffffff);
    random_phase(120);

    in_idle_pct = 0;
    out_idle_pct = 0;
    set_solver(24'h02a000, 24'h015000, 1'b0, 1'b0, 24'd0, 24'd0);
    random_phase(180);
    set_solver(24'h400000, 24'h3fffff, 1'b1, 1'b1, 24'h55aa55, 24'haa55aa);
    random_phase(160);

    if (mismatches == 0) $display("planar_two_bone_ik_solver_unit regression: pass");
    else $display("planar_two_bone_ik_solver_unit regression: fail");
    $finish;
  end

  initial begin
    #5ms;
    $display("planar_two_bone_ik_solver_unit regression: fail");
    $finish;
  end

endmodule

// ===== sim.f =====
src/pik_pkg.sv
src/pik_atan2.sv
src/planar_two_bone_ik_solver_unit.sv
tb/planar_two_bone_ik_solver_unit_tb.sv
